/* hdl/srr_pkg.sv */
// ----------------------------------------------------------------------------
// srr_pkg
// Shared widths and result kind codes of the selective repeat receiver.
// ----------------------------------------------------------------------------
package srr_pkg;

  localparam int unsigned SEQ_W  = 8;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned KIND_W = 2;

  localparam logic [KIND_W-1:0] KIND_ACK_OK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACK_BAD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd2;

endpackage

/* hdl/srr_intf.sv */
// ----------------------------------------------------------------------------
// srr_intf
// Valid/ready channels for received packets and for acks and deliveries.
// ----------------------------------------------------------------------------
interface srr_in_if;
  import srr_pkg::*;

  logic              valid;
  logic              ready;
  logic [SEQ_W-1:0]  seq_num;
  logic              crc_good;
  logic              is_end;
  logic [DATA_W-1:0] payload;

  modport source (output valid, output seq_num, output crc_good, output is_end,
                  output payload, input ready);
  modport sink   (input valid, input seq_num, input crc_good, input is_end,
                  input payload, output ready);
endinterface

interface srr_out_if;
  import srr_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [SEQ_W-1:0]  ack_seq;
  logic [DATA_W-1:0] data_out;
  logic              data_is_end;
  logic              last;

  modport source (output valid, output kind, output ack_seq, output data_out,
                  output data_is_end, output last, input ready);
  modport sink   (input valid, input kind, input ack_seq, input data_out,
                  input data_is_end, input last, output ready);
endinterface

/* hdl/selective_repeat_receiver_top.sv */
// ----------------------------------------------------------------------------
// selective_repeat_receiver_top
// Selective repeat ARQ receiver: acks packets, buffers the window, delivers
// in order.
// ----------------------------------------------------------------------------
// One packet is handled at a time. A packet that delivers nothing passes
// through accept, then ack with the window store write. When deliveries
// follow, the head slot of the single port store memory is read first,
// then the packets are delivered one after another, the next slot being
// read while the current one is sent. A stalled output register holds the
// sequence up. After the end packet is delivered every packet is taken and
// dropped until reset.
module selective_repeat_receiver_top #(
  parameter int unsigned WINDOW = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  srr_in_if.sink    in_i,
  srr_out_if.source out_o
);
  import srr_pkg::*;

  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [SEQ_W-1:0]  WIN_L     = SEQ_W'(WINDOW);
  localparam logic [SLOT_W:0]   WIN_S     = (SLOT_W+1)'(WINDOW);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ACK  = 4'b0010,
    ST_RD   = 4'b0100,
    ST_DLV  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [SEQ_W-1:0]  base_q;
  logic [SLOT_W-1:0] head_q;
  logic [WINDOW-1:0] held_q;
  logic              finished_q;

  logic [SEQ_W-1:0]  seq_q;
  logic              good_q;
  logic              end_q;
  logic [DATA_W-1:0] data_q;

  logic [DATA_W:0]   store_mem [WINDOW];
  logic [DATA_W:0]   rd_data_q;

  logic              out_valid_q;
  logic [KIND_W-1:0] kind_q;
  logic [SEQ_W-1:0]  ack_seq_q;
  logic [DATA_W-1:0] data_out_q;
  logic              data_is_end_q;
  logic              last_q;

  logic [SEQ_W-1:0]  offset;
  logic [SLOT_W:0]   slot_sum;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] head_next;
  logic [SLOT_W-1:0] rd_addr;
  logic              in_win;
  logic              do_store;
  logic              has_dlv;
  logic              more;
  logic              out_free;
  logic              accept;
  logic              rd_en;
  logic              emit_ack;
  logic              emit_dlv;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  assign offset    = seq_q - base_q;
  assign in_win    = offset < WIN_L;
  assign slot_sum  = {1'b0, head_q} + offset[SLOT_W:0];
  assign slot      = (slot_sum >= WIN_S) ? SLOT_W'(slot_sum - WIN_S) : slot_sum[SLOT_W-1:0];
  assign do_store  = good_q && in_win && !held_q[slot];
  assign has_dlv   = good_q && (held_q[head_q] || (do_store && (slot == head_q)));
  assign head_next = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
  assign more      = held_q[head_next] && (head_next != head_q) && !rd_data_q[DATA_W];

  assign emit_ack = (state_q == ST_ACK) && out_free;
  assign emit_dlv = (state_q == ST_DLV) && out_free;
  assign rd_en    = (state_q == ST_RD) || (emit_dlv && more);
  assign rd_addr  = (state_q == ST_DLV) ? head_next : head_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept && !finished_q) state_d = ST_ACK;
      ST_ACK:  if (out_free) state_d = has_dlv ? ST_RD : ST_IDLE;
      ST_RD:   state_d = ST_DLV;
      ST_DLV:  if (out_free && !more) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      base_q     <= '0;
      head_q     <= '0;
      held_q     <= '0;
      finished_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit_ack && do_store) held_q[slot] <= 1'b1;
      if (emit_dlv) begin
        held_q[head_q] <= 1'b0;
        base_q         <= base_q + 1'b1;
        head_q         <= head_next;
        if (rd_data_q[DATA_W]) finished_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      seq_q  <= in_i.seq_num;
      good_q <= in_i.crc_good;
      end_q  <= in_i.is_end;
      data_q <= in_i.payload;
    end
  end

  // window store
  always_ff @(posedge clk_i) begin
    if (emit_ack && do_store) store_mem[slot] <= {end_q, data_q};
    if (rd_en) rd_data_q <= store_mem[rd_addr];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_ack || emit_dlv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_ack) begin
      kind_q        <= good_q ? KIND_ACK_OK : KIND_ACK_BAD;
      ack_seq_q     <= good_q ? seq_q : base_q;
      data_out_q    <= '0;
      data_is_end_q <= 1'b0;
      last_q        <= !has_dlv;
    end else if (emit_dlv) begin
      kind_q        <= KIND_DELIVER;
      ack_seq_q     <= base_q;
      data_out_q    <= rd_data_q[DATA_W-1:0];
      data_is_end_q <= rd_data_q[DATA_W];
      last_q        <= !more;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = kind_q;
  assign out_o.ack_seq     = ack_seq_q;
  assign out_o.data_out    = data_out_q;
  assign out_o.data_is_end = data_is_end_q;
  assign out_o.last        = last_q;

endmodule

/* hdl/srr_checker.sv */
// ----------------------------------------------------------------------------
// srr_checker
// Port level checks on the result channel of the receiver.
// ----------------------------------------------------------------------------
module srr_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [srr_pkg::KIND_W-1:0] kind_i,
  input logic [srr_pkg::DATA_W-1:0] data_out_i,
  input logic                      data_is_end_i,
  input logic                      last_i
);
  import srr_pkg::*;

  // a pending transaction is not withdrawn
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (kind_i == KIND_ACK_OK || kind_i == KIND_ACK_BAD ||
                     kind_i == KIND_DELIVER))
    else $error("unknown result kind");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i != KIND_DELIVER |-> data_out_i == '0 && !data_is_end_i)
    else $error("ack carries data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == KIND_ACK_BAD || data_is_end_i) |-> last_i)
    else $error("bad ack or end delivery not last");

  // nothing follows the end delivery
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && data_is_end_i |=> !out_valid_i)
    else $error("result after end delivery");

endmodule

bind selective_repeat_receiver_top srr_checker u_srr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .kind_i        (out_o.kind),
  .data_out_i    (out_o.data_out),
  .data_is_end_i (out_o.data_is_end),
  .last_i        (out_o.last)
);
